// ===== rtl/ffea_pkg.sv =====
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and constants of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

    // Default depth of the free-extent table.
    localparam int FREE_SLOTS_DEF    = 64;

    // Block layout and address arithmetic.
    localparam int HEADER_BYTES      = 8;
    localparam int ALIGN_BYTES       = 8;
    localparam int ADDR_BITS         = 32;
    localparam int MIN_SPLIT_PAYLOAD = 8;

    // Reset value of the heap limit register.
    localparam logic [31:0] HEAP_LIMIT_RESET = 32'd65536;

    // Request types.
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE   = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] request_size;
        logic [31:0] block_address;
    } req_t;

    typedef struct packed {
        logic [31:0] payload_address;
        logic [31:0] granted_size;
        logic [1:0]  status;
    } rsp_t;

    // One free extent: header address and payload size.
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
    } entry_t;

    typedef struct packed {
        logic [31:0] heap_base;
        logic [31:0] heap_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ASCAN,
        ST_AHIT,
        ST_BUMP0,
        ST_BUMP1,
        ST_RINIT,
        ST_RSCAN,
        ST_RNEXT,
        ST_RPREV,
        ST_SUP,
        ST_WR,
        ST_SDN,
        ST_TCHK,
        ST_TINIT,
        ST_TSCAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/ffea_table.sv =====
// ----------------------------------------------------------------------------
// ffea_table
// Free-extent table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffea_table #(
    parameter int SLOTS = ffea_pkg::FREE_SLOTS_DEF,
    parameter int AW    = $clog2(SLOTS)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  ffea_pkg::entry_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output ffea_pkg::entry_t rd_data
);
    import ffea_pkg::*;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ffea_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffea_ctrl
// Request sequencer: walks the extent table for first fit, sorted insert,
// coalescing and cursor pull-down, and holds the result register.
// ----------------------------------------------------------------------------
module ffea_ctrl #(
    parameter int SLOTS = ffea_pkg::FREE_SLOTS_DEF,
    parameter int AW    = $clog2(SLOTS),
    parameter int CW    = $clog2(SLOTS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ffea_pkg::cfg_t   cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  ffea_pkg::req_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ffea_pkg::rsp_t   m_data,
    output logic             tbl_wr_en,
    output logic [AW-1:0]    tbl_wr_addr,
    output ffea_pkg::entry_t tbl_wr_data,
    output logic [AW-1:0]    tbl_rd_addr,
    input  ffea_pkg::entry_t tbl_rd_data
);
    import ffea_pkg::*;

    localparam logic [31:0] HDR        = 32'(HEADER_BYTES);
    localparam logic [31:0] SPLIT_MIN  = 32'(HEADER_BYTES + MIN_SPLIT_PAYLOAD);
    localparam logic [32:0] ALIGN_M1   = 33'(ALIGN_BYTES - 1);
    localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);
    localparam logic [CW-1:0] ONE_C    = CW'(1);
    localparam logic [CW-1:0] TWO_C    = CW'(2);

    // Control state.
    state_t         state_reg, state_next;
    state_t         ret_reg, ret_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [31:0]    top_reg, top_next;
    logic           chk_reg, chk_next;
    logic           m_valid_reg, m_valid_next;

    // Working registers.
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  cur_reg, cur_next;
    logic [CW-1:0]  p_reg, p_next;
    logic [31:0]    s_reg, s_next;
    logic [31:0]    z_reg, z_next;
    logic [31:0]    need_reg, need_next;
    logic           prev_vld_reg, prev_vld_next;
    entry_t         prev_reg, prev_next;
    logic           next_vld_reg, next_vld_next;
    entry_t         nxt_reg, nxt_next;
    logic           mnext_reg, mnext_next;
    logic           drop_reg, drop_next;
    rsp_t           res_reg, res_next;
    rsp_t           m_data_reg, m_data_next;

    // Datapath helpers.
    logic [31:0]    req_sz;
    logic [32:0]    need_w;
    logic [31:0]    cur_end;
    logic [31:0]    rd_end;
    logic [31:0]    prev_end;
    logic [31:0]    base_rnd;
    logic [33:0]    bump_end;
    logic           issue;
    logic [CW-1:0]  rd_idx;
    logic [CW-1:0]  wr_idx;

    assign req_sz   = (s_data.request_size == 32'd0) ? 32'd1 : s_data.request_size;
    assign need_w   = ({1'b0, req_sz} + ALIGN_M1) & ~ALIGN_M1;
    assign cur_end  = s_reg + HDR + z_reg;
    assign rd_end   = tbl_rd_data.start + HDR + tbl_rd_data.size;
    assign prev_end = prev_reg.start + HDR + prev_reg.size;
    assign base_rnd = (cfg.heap_base + ALIGN_M1[31:0]) & ~ALIGN_M1[31:0];
    assign bump_end = {2'b00, top_reg} + {2'b00, HDR} + {2'b00, need_reg};

    // Sequencer: next state, table accesses and result.
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cnt_next      = cnt_reg;
        top_next      = top_reg;
        chk_next      = chk_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        p_next        = p_reg;
        s_next        = s_reg;
        z_next        = z_reg;
        need_next     = need_reg;
        prev_vld_next = prev_vld_reg;
        prev_next     = prev_reg;
        next_vld_next = next_vld_reg;
        nxt_next      = nxt_reg;
        mnext_next    = mnext_reg;
        drop_next     = drop_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        s_ready       = 1'b0;
        tbl_wr_en     = 1'b0;
        tbl_wr_data   = '0;
        wr_idx        = '0;
        rd_idx        = idx_reg;
        issue         = (idx_reg < cnt_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_next      = '0;
                    idx_next      = '0;
                    chk_next      = 1'b0;
                    prev_vld_next = 1'b0;
                    if (s_data.req_type == REQ_RELEASE) begin
                        if (s_data.block_address == 32'd0) begin
                            state_next = ST_DONE;
                        end else if (cnt_reg == SLOTS_C) begin
                            res_next.status = STATUS_TABLE_FULL;
                            state_next      = ST_DONE;
                        end else begin
                            s_next     = s_data.block_address - HDR;
                            z_next     = s_data.request_size;
                            state_next = ST_RSCAN;
                        end
                    end else begin
                        if (need_w[32]) begin
                            res_next.status = STATUS_NO_SPACE;
                            state_next      = ST_DONE;
                        end else begin
                            need_next  = need_w[31:0];
                            state_next = ST_ASCAN;
                        end
                    end
                end
            end

            // First-fit search, one entry a cycle.
            ST_ASCAN: begin
                if (chk_reg && (tbl_rd_data.size >= need_reg)) begin
                    s_next     = tbl_rd_data.start;
                    z_next     = tbl_rd_data.size - need_reg;
                    cur_next   = idx_reg - ONE_C;
                    chk_next   = 1'b0;
                    state_next = ST_AHIT;
                end else begin
                    chk_next = issue;
                    idx_next = idx_reg + CW'(issue);
                    if (!issue && !chk_reg) begin
                        state_next = ST_BUMP0;
                    end
                end
            end

            // Fit found: grant, decide on a split, then drop the entry.
            ST_AHIT: begin
                res_next.payload_address = s_reg + HDR;
                if (z_reg >= SPLIT_MIN) begin
                    res_next.granted_size = need_reg;
                    s_next   = s_reg + HDR + need_reg;
                    z_next   = z_reg - HDR;
                    ret_next = ST_RINIT;
                end else begin
                    res_next.granted_size = need_reg + z_reg;
                    ret_next = ST_DONE;
                end
                idx_next   = cur_reg + ONE_C;
                chk_next   = 1'b0;
                state_next = ST_SDN;
            end

            // Start the cursor from the aligned base when it is not yet set.
            ST_BUMP0: begin
                if (top_reg == 32'd0) begin
                    top_next = base_rnd;
                end
                state_next = ST_BUMP1;
            end

            ST_BUMP1: begin
                if (bump_end > {2'b00, cfg.heap_limit}) begin
                    res_next.status = STATUS_NO_SPACE;
                end else begin
                    res_next.payload_address = top_reg + HDR;
                    res_next.granted_size    = need_reg;
                    top_next                 = bump_end[31:0];
                end
                state_next = ST_DONE;
            end

            ST_RINIT: begin
                idx_next      = '0;
                chk_next      = 1'b0;
                prev_vld_next = 1'b0;
                state_next    = ST_RSCAN;
            end

            // Find the insert position, keeping both neighbours.
            ST_RSCAN: begin
                if (chk_reg && (tbl_rd_data.start >= s_reg)) begin
                    p_next        = idx_reg - ONE_C;
                    next_vld_next = 1'b1;
                    nxt_next      = tbl_rd_data;
                    chk_next      = 1'b0;
                    state_next    = ST_RNEXT;
                end else begin
                    if (chk_reg) begin
                        prev_vld_next = 1'b1;
                        prev_next     = tbl_rd_data;
                    end
                    chk_next = issue;
                    idx_next = idx_reg + CW'(issue);
                    if (!issue && !chk_reg) begin
                        p_next        = cnt_reg;
                        next_vld_next = 1'b0;
                        state_next    = ST_RNEXT;
                    end
                end
            end

            // Merge with the following extent.
            ST_RNEXT: begin
                mnext_next = next_vld_reg && (cur_end == nxt_reg.start);
                if (next_vld_reg && (cur_end == nxt_reg.start)) begin
                    z_next = z_reg + HDR + nxt_reg.size;
                end
                state_next = ST_RPREV;
            end

            // Merge with the preceding extent and choose the table update.
            ST_RPREV: begin
                if (prev_vld_reg && (prev_end == s_reg)) begin
                    s_next     = prev_reg.start;
                    z_next     = prev_reg.size + HDR + z_reg;
                    cur_next   = p_reg - ONE_C;
                    drop_next  = mnext_reg;
                    state_next = ST_WR;
                end else begin
                    cur_next  = p_reg;
                    drop_next = 1'b0;
                    if (mnext_reg) begin
                        state_next = ST_WR;
                    end else begin
                        idx_next   = cnt_reg;
                        chk_next   = 1'b0;
                        state_next = ST_SUP;
                    end
                end
            end

            // Open a slot at the insert position, moving entries up.
            ST_SUP: begin
                issue  = (idx_reg > p_reg);
                rd_idx = idx_reg - ONE_C;
                if (chk_reg) begin
                    tbl_wr_en   = 1'b1;
                    wr_idx      = idx_reg + ONE_C;
                    tbl_wr_data = tbl_rd_data;
                end
                chk_next = issue;
                if (issue) begin
                    idx_next = idx_reg - ONE_C;
                end
                if (!issue && !chk_reg) begin
                    cnt_next   = cnt_reg + ONE_C;
                    state_next = ST_WR;
                end
            end

            ST_WR: begin
                tbl_wr_en   = 1'b1;
                wr_idx      = cur_reg;
                tbl_wr_data = '{start: s_reg, size: z_reg};
                if (drop_reg) begin
                    idx_next   = cur_reg + TWO_C;
                    chk_next   = 1'b0;
                    ret_next   = ST_TCHK;
                    state_next = ST_SDN;
                end else begin
                    state_next = ST_TCHK;
                end
            end

            // Remove one entry, moving the ones above it down.
            ST_SDN: begin
                if (chk_reg) begin
                    tbl_wr_en   = 1'b1;
                    wr_idx      = idx_reg - TWO_C;
                    tbl_wr_data = tbl_rd_data;
                end
                chk_next = issue;
                idx_next = idx_reg + CW'(issue);
                if (!issue && !chk_reg) begin
                    cnt_next   = cnt_reg - ONE_C;
                    state_next = ret_reg;
                end
            end

            // An extent ending at the cursor goes back into the cursor.
            ST_TCHK: begin
                if (cur_end == top_reg) begin
                    top_next   = s_reg;
                    idx_next   = cur_reg + ONE_C;
                    chk_next   = 1'b0;
                    ret_next   = ST_TINIT;
                    state_next = ST_SDN;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_TINIT: begin
                idx_next   = '0;
                chk_next   = 1'b0;
                state_next = ST_TSCAN;
            end

            // Look for another extent that now ends at the cursor.
            ST_TSCAN: begin
                if (chk_reg && (rd_end == top_reg)) begin
                    cur_next   = idx_reg - ONE_C;
                    s_next     = tbl_rd_data.start;
                    z_next     = tbl_rd_data.size;
                    chk_next   = 1'b0;
                    state_next = ST_TCHK;
                end else begin
                    chk_next = issue;
                    idx_next = idx_reg + CW'(issue);
                    if (!issue && !chk_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    assign tbl_rd_addr = rd_idx[AW-1:0];
    assign tbl_wr_addr = wr_idx[AW-1:0];
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_DONE;
            cnt_reg     <= '0;
            top_reg     <= '0;
            chk_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cnt_reg     <= cnt_next;
            top_reg     <= top_next;
            chk_reg     <= chk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        p_reg        <= p_next;
        s_reg        <= s_next;
        z_reg        <= z_next;
        need_reg     <= need_next;
        prev_vld_reg <= prev_vld_next;
        prev_reg     <= prev_next;
        next_vld_reg <= next_vld_next;
        nxt_reg      <= nxt_next;
        mnext_reg    <= mnext_next;
        drop_reg     <= drop_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

// ===== rtl/first_fit_extent_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// Heap allocator with an address-ordered free-extent table, first-fit
// search, splitting, coalescing and a bump cursor bounded by a limit.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  s_       | in        | s_valid / s_ready   | req_t  (type, size, address)
//  m_       | out       | m_valid / m_ready   | rsp_t  (address, size, status)
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item is worked on at a time; each table walk reads one entry a cycle
//  through the table's single read port. A failed search is followed by a
//  bump from the cursor, and each extent folded back into the cursor costs
//  a removal sweep plus a full walk of the table.
//  Reset clears the extent count and the cursor; no clearing pass is made.
//  A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator #(
    parameter int FREE_SLOTS = ffea_pkg::FREE_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ffea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ffea_pkg::req_t                 s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ffea_pkg::rsp_t                 m_data
);
    import ffea_pkg::*;

    localparam int AW = $clog2(FREE_SLOTS);

    logic [31:0]  heap_base_reg;
    logic [31:0]  heap_limit_reg;
    cfg_t         cfg;
    logic         tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    entry_t       tbl_wr_data;
    logic [AW-1:0] tbl_rd_addr;
    entry_t       tbl_rd_data;

    // Configuration registers; a write is taken in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= '0;
            heap_limit_reg <= HEAP_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                REG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
            endcase
        end
    end

    assign cfg = '{heap_base: heap_base_reg, heap_limit: heap_limit_reg};

    ffea_ctrl #(
        .SLOTS (FREE_SLOTS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data)
    );

    ffea_table #(
        .SLOTS (FREE_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

endmodule

// ===== rtl/ffea_checker.sv =====
// ----------------------------------------------------------------------------
// ffea_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ffea_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input ffea_pkg::rsp_t m_data
);
    import ffea_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // One item at a time: no second item in the cycle after one is taken.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while another is in work");

    // A failed request grants nothing.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STATUS_OK) |->
            (m_data.payload_address == 32'd0) && (m_data.granted_size == 32'd0))
        else $error("failure with non-zero grant");

    // A granted block always has usable bytes.
    a_grant_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.payload_address != 32'd0) |-> (m_data.granted_size != 32'd0))
        else $error("block granted with zero size");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/first_fit_extent_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_tb
// Self-checking bench for the first-fit extent allocator. Requests go in
// under random idling and stalls. Each one is predicted by a behavioural
// copy of the free-extent table and the top cursor. Every result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_tb;
    import ffea_pkg::*;

    typedef bit [63:0] u64;
    localparam u64 AMASK = 64'hFFFF_FFFF;
    localparam int SLOTS = FREE_SLOTS_DEF;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    req_t                 s_data;
    logic                 m_valid;
    logic                 m_ready;
    rsp_t                 m_data;

    first_fit_extent_allocator #(.FREE_SLOTS(SLOTS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Shadow of the allocator state.
    u64 free_start [SLOTS];
    u64 free_size  [SLOTS];
    int free_count;
    u64 top_ptr;
    u64 base_reg;
    u64 limit_reg;

    // Results still to come, and blocks currently held by the caller.
    rsp_t        grant_q [$];
    logic [31:0] held_addr [$];
    logic [31:0] held_size [$];

    int idle_pct;
    int stall_pct;
    int err_count;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog.
    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic u64 align_up(u64 v);
        return ((v + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic u64 free_end(int i);
        return (free_start[i] + HEADER_BYTES + free_size[i]) & AMASK;
    endfunction

    function automatic void free_drop(int i);
        for (int j = i; j < free_count - 1; j++) begin
            free_start[j] = free_start[j+1];
            free_size[j]  = free_size[j+1];
        end
        free_count--;
    endfunction

    // Sorted insert, merging with both neighbours, then folding into the cursor.
    function automatic logic [1:0] free_insert(u64 st, u64 sz);
        int p;
        int cur;
        bit found;
        p = 0;
        if (free_count >= SLOTS) return STATUS_TABLE_FULL;
        while (p < free_count && free_start[p] < st) p++;
        for (int i = free_count; i > p; i--) begin
            free_start[i] = free_start[i-1];
            free_size[i]  = free_size[i-1];
        end
        free_start[p] = st & AMASK;
        free_size[p]  = sz & AMASK;
        free_count++;
        cur = p;
        if (cur + 1 < free_count && free_end(cur) == free_start[cur+1]) begin
            free_size[cur] = (free_size[cur] + HEADER_BYTES + free_size[cur+1]) & AMASK;
            free_drop(cur + 1);
        end
        if (cur > 0 && free_end(cur - 1) == free_start[cur]) begin
            free_size[cur-1] = (free_size[cur-1] + HEADER_BYTES + free_size[cur]) & AMASK;
            free_drop(cur);
            cur--;
        end
        found = 1'b1;
        while (found) begin
            if (free_end(cur) != top_ptr) break;
            top_ptr = free_start[cur];
            free_drop(cur);
            found = 1'b0;
            for (int i = 0; i < free_count; i++) begin
                if (free_end(i) == top_ptr) begin
                    cur = i;
                    found = 1'b1;
                    break;
                end
            end
        end
        return STATUS_OK;
    endfunction

    // Expected result of one request; updates the shadow state.
    function automatic rsp_t heap_predict(req_t r);
        rsp_t o;
        u64 want;
        u64 need;
        u64 st;
        u64 rem;
        u64 fin;
        o = '0;
        want = u64'(r.request_size);
        if (r.req_type == REQ_RELEASE) begin
            if (r.block_address != 0)
                o.status = free_insert((u64'(r.block_address) - HEADER_BYTES) & AMASK, want);
            return o;
        end
        if (want == 0) want = 1;
        need = align_up(want);
        if (need > AMASK) begin
            o.status = STATUS_NO_SPACE;
            return o;
        end
        for (int i = 0; i < free_count; i++) begin
            if (free_size[i] >= need) begin
                st  = free_start[i];
                rem = free_size[i] - need;
                free_drop(i);
                if (rem >= HEADER_BYTES + MIN_SPLIT_PAYLOAD && free_count < SLOTS)
                    void'(free_insert((st + HEADER_BYTES + need) & AMASK, rem - HEADER_BYTES));
                else
                    need += rem;
                o.payload_address = 32'((st + HEADER_BYTES) & AMASK);
                o.granted_size    = need[31:0];
                return o;
            end
        end
        if (top_ptr == 0) top_ptr = align_up(base_reg) & AMASK;
        if (top_ptr > AMASK - HEADER_BYTES - need) begin
            o.status = STATUS_NO_SPACE;
            return o;
        end
        fin = top_ptr + HEADER_BYTES + need;
        if (fin > limit_reg) begin
            o.status = STATUS_NO_SPACE;
            return o;
        end
        o.payload_address = top_ptr[31:0] + HEADER_BYTES;
        o.granted_size    = need[31:0];
        top_ptr = fin;
        return o;
    endfunction

    // Result checker with random back-pressure.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, m_data);
                err_count++;
            end else begin
                want = grant_q.pop_front();
                if (m_data.payload_address !== want.payload_address) begin
                    $display("%0t: payload_address expected %h actual %h",
                             $realtime, want.payload_address, m_data.payload_address);
                    err_count++;
                end
                if (m_data.granted_size !== want.granted_size) begin
                    $display("%0t: granted_size expected %h actual %h",
                             $realtime, want.granted_size, m_data.granted_size);
                    err_count++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, m_data.status);
                    err_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Sends one item, predicts its result and tracks blocks held by the caller.
    task automatic send_item(req_t r);
        rsp_t p;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        p = heap_predict(r);
        grant_q.push_back(p);
        if (r.req_type == REQ_ALLOC && p.status == STATUS_OK) begin
            held_addr.push_back(p.payload_address);
            held_size.push_back(p.granted_size);
        end
    endtask

    task automatic alloc_item(logic [31:0] sz);
        send_item('{req_type: REQ_ALLOC, request_size: sz, block_address: 32'd0});
    endtask

    task automatic release_raw(logic [31:0] addr, logic [31:0] sz);
        send_item('{req_type: REQ_RELEASE, request_size: sz, block_address: addr});
    endtask

    task automatic release_held(int idx);
        logic [31:0] a;
        logic [31:0] z;
        a = held_addr[idx];
        z = held_size[idx];
        held_addr.delete(idx);
        held_size.delete(idx);
        release_raw(a, z);
    endtask

    // A release spanning from address zero to the cursor brings it back to unset.
    task automatic park_cursor();
        if (top_ptr != 0) release_raw(32'd8, top_ptr[31:0] - 32'd8);
    endtask

    task automatic drain_heap();
        while (held_addr.size() > 0) release_held($urandom_range(held_addr.size() - 1));
        park_cursor();
    endtask

    // Waits until every result is back and the block has settled.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (grant_q.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_HEAP_BASE) base_reg = u64'(val);
        else limit_reg = u64'(val);
        @(posedge aclk);
    endtask

    task automatic set_heap(logic [31:0] b, logic [31:0] l);
        wait_idle();
        write_reg(REG_HEAP_BASE, b);
        write_reg(REG_HEAP_LIMIT, l);
    endtask

    // Size overflow, bump overflow, zero sizes, release of zero, split and merge.
    task automatic test_special_cases();
        set_heap(32'hFFFF_FFE9, 32'hFFFF_FFFF);
        alloc_item(32'd1);
        park_cursor();
        set_heap(32'h0000_1003, 32'h0000_1100);
        alloc_item(32'd0);
        alloc_item(32'd7);
        alloc_item(32'd8);
        alloc_item(32'd9);
        alloc_item(32'd64);
        alloc_item(32'hFFFF_FFFF);
        alloc_item(32'hFFFF_FFF9);
        alloc_item(32'hFFFF_FFF8);
        alloc_item(32'h0000_0200);
        release_raw(32'd0, 32'hFFFF_FFFF);
        release_held(3);
        release_held(2);
        alloc_item(32'd1);
        alloc_item(32'd16);
        release_held(1);
        release_held(0);
        alloc_item(32'd200);
        drain_heap();
    endtask

    // Fragments the heap until the free table overflows.
    task automatic test_table_full();
        set_heap(32'd0, HEAP_LIMIT_RESET);
        for (int k = 0; k < SLOTS * 2 + 2; k++) alloc_item(32'd8);
        for (int k = 0; k <= SLOTS; k++) release_held(k);
        for (int k = 0; k < 6; k++) alloc_item($urandom_range(1, 24));
        drain_heap();
    endtask

    // Random traffic: mostly alloc and release of held blocks, some noise.
    task automatic test_random_traffic(int n, logic [31:0] b, logic [31:0] l, int ip, int sp);
        int pick;
        set_heap(b, l);
        idle_pct  = ip;
        stall_pct = sp;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 52 || (pick < 92 && held_addr.size() == 0)) begin
                pick = $urandom_range(99);
                if (pick < 85) alloc_item($urandom_range(0, 256));
                else if (pick < 97) alloc_item($urandom_range(257, 4096));
                else alloc_item($urandom);
            end else if (pick < 92) begin
                release_held($urandom_range(held_addr.size() - 1));
            end else if (pick < 96) begin
                release_raw(32'd0, $urandom);
            end else begin
                release_raw($urandom, $urandom);
            end
        end
        drain_heap();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_HEAP_BASE;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        err_count = 0;
        free_count = 0;
        top_ptr   = 0;
        base_reg  = 0;
        limit_reg = u64'(HEAP_LIMIT_RESET);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_cases();
        test_table_full();
        test_random_traffic(260, 32'd0, HEAP_LIMIT_RESET, 0, 0);
        test_random_traffic(260, 32'h0000_1003, 32'h0000_9000, 68, 0);
        test_random_traffic(260, 32'h0000_0100, 32'hFFFF_FFFF, 0, 68);
        test_random_traffic(50, 32'hFFFF_FFFF, 32'd0, 9, 9);
        test_random_traffic(220, 32'h0000_2000, 32'h0000_4000, 9, 9);

        wait_idle();
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
